// File: src/tekd_pkg.sv
package tekd_pkg;

    localparam int STATE_W = 3;

    localparam logic [STATE_W-1:0] ST_PLAIN = 3'd0;
    localparam logic [STATE_W-1:0] ST_ESC   = 3'd1;
    localparam logic [STATE_W-1:0] ST_CSI   = 3'd2;
    localparam logic [STATE_W-1:0] ST_SS3   = 3'd3;
    localparam logic [STATE_W-1:0] ST_PGUP  = 3'd4;
    localparam logic [STATE_W-1:0] ST_PGDN  = 3'd5;
    localparam logic [STATE_W-1:0] ST_INS   = 3'd6;
    localparam logic [STATE_W-1:0] ST_DEL   = 3'd7;

    localparam logic [7:0] CH_AT    = 8'd64;
    localparam logic [7:0] CH_SPACE = 8'd32;
    localparam logic [7:0] CH_ESC   = 8'd27;
    localparam logic [7:0] CH_SS3   = 8'd79;
    localparam logic [7:0] CH_CSI   = 8'd91;
    localparam logic [7:0] CH_UP    = 8'd65;
    localparam logic [7:0] CH_DOWN  = 8'd66;
    localparam logic [7:0] CH_RIGHT = 8'd67;
    localparam logic [7:0] CH_LEFT  = 8'd68;
    localparam logic [7:0] CH_END   = 8'd70;
    localparam logic [7:0] CH_HOME  = 8'd72;
    localparam logic [7:0] CH_F1    = 8'd80;
    localparam logic [7:0] CH_F5    = 8'd84;
    localparam logic [7:0] CH_TILDE = 8'd126;
    localparam logic [7:0] CH_TWO   = 8'd50;
    localparam logic [7:0] CH_THREE = 8'd51;
    localparam logic [7:0] CH_FIVE  = 8'd53;
    localparam logic [7:0] CH_SIX   = 8'd54;

    localparam logic [7:0] SP_DELETE = 8'd8;
    localparam logic [7:0] SP_F1     = 8'd9;

    localparam logic [1:0] STS_OK      = 2'd0;
    localparam logic [1:0] STS_IO_ERR  = 2'd1;
    localparam logic [1:0] STS_INVALID = 2'd2;

    typedef struct packed {
        logic       valid;
        logic       special;
        logic [7:0] value;
        logic       ctrl;
        logic [1:0] status;
    } t_key_result;

endpackage

// File: src/tekd_decode.sv
module tekd_decode
    import tekd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_fire,
    input  logic [7:0]  i_byte,
    output t_key_result o_result
);

    logic [STATE_W-1:0] r_state;
    logic [STATE_W-1:0] n_state;
    t_key_result        w_res;

    always_comb begin
        n_state = ST_PLAIN;
        w_res   = '0;
        unique case (r_state)
            ST_PLAIN: begin
                if (i_byte == CH_ESC) begin
                    n_state = ST_ESC;
                end else if (i_byte < CH_SPACE) begin
                    w_res.valid = 1'b1;
                    w_res.value = CH_AT + i_byte;
                    w_res.ctrl  = 1'b1;
                end else begin
                    w_res.valid = 1'b1;
                    w_res.value = i_byte;
                end
            end
            ST_ESC: begin
                if (i_byte == CH_ESC) begin
                    w_res.status = STS_IO_ERR;
                end else if (i_byte == CH_SS3) begin
                    n_state = ST_SS3;
                end else if (i_byte == CH_CSI) begin
                    n_state = ST_CSI;
                end
            end
            ST_CSI: begin
                case (i_byte) inside
                    CH_UP, CH_DOWN, CH_RIGHT, CH_LEFT, CH_END, CH_HOME: begin
                        w_res.valid   = 1'b1;
                        w_res.special = 1'b1;
                        w_res.value   = i_byte - CH_UP;
                    end
                    CH_FIVE:  n_state = ST_PGUP;
                    CH_SIX:   n_state = ST_PGDN;
                    CH_TWO:   n_state = ST_INS;
                    CH_THREE: n_state = ST_DEL;
                    default:  n_state = ST_PLAIN;
                endcase
            end
            ST_SS3: begin
                if (i_byte >= CH_F1 && i_byte <= CH_F5) begin
                    w_res.valid   = 1'b1;
                    w_res.special = 1'b1;
                    w_res.value   = i_byte - CH_F1 + SP_F1;
                end else begin
                    w_res.status = STS_INVALID;
                end
            end
            ST_DEL: begin
                if (i_byte == CH_TILDE) begin
                    w_res.valid   = 1'b1;
                    w_res.special = 1'b1;
                    w_res.value   = SP_DELETE;
                end else begin
                    w_res.status = STS_INVALID;
                end
            end
            default: begin
                // page up, page down, insert swallow the tilde
                if (i_byte != CH_TILDE) begin
                    w_res.status = STS_INVALID;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_PLAIN;
        end else if (i_fire) begin
            r_state <= n_state;
        end
    end

    assign o_result = w_res;

    a_key_returns_plain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && w_res.valid) |=> (r_state == ST_PLAIN))
        else $error("decoder did not return to plain after a key");

    a_error_returns_plain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && w_res.status != STS_OK) |=> (r_state == ST_PLAIN))
        else $error("decoder did not return to plain after an error");

    a_ctrl_from_plain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && w_res.ctrl) |-> (r_state == ST_PLAIN))
        else $error("control key decoded outside plain state");

endmodule

// File: src/terminal_escape_key_decoder_top.sv
// pipeline: an accepted byte is registered in the input stage, then decoded into the result stage
// throughput: one byte per cycle while m_axis_tready does not stall the result stage, set by
// the combinational decode between the input register and the result register
// reset: synchronous active-low, empties both stages and puts the decoder in plain state
module terminal_escape_key_decoder_top
    import tekd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // in_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // key_valid, key_value[7:0], ctrl_mark, status[1:0]
    output logic        m_axis_tuser    // key_special
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_out_valid;
    t_key_result r_out;
    t_key_result w_res;
    logic        w_adv;

    assign w_adv         = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    tekd_decode u_decode (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (w_adv),
        .i_byte   (r_in_byte),
        .o_result (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
        end
        if (w_adv) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out.status, r_out.ctrl, r_out.value, r_out.valid};
    assign m_axis_tuser  = r_out.special;

    a_err_no_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.status != STS_OK) |-> !r_out.valid)
        else $error("error status beat carries a key");

    a_special_is_key: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out.special || r_out.ctrl)) |-> r_out.valid)
        else $error("special or control mark without a key");

    a_ctrl_not_special: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.ctrl) |-> !r_out.special)
        else $error("control key marked special");

    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> r_in_valid)
        else $error("accepted beat not held in input stage");

endmodule

// File: verif/tb_terminal_escape_key_decoder_top.sv
module tb_terminal_escape_key_decoder_top
    import tekd_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_BYTES = 1600;
    localparam int HOLD_AT_BEAT = 120;
    localparam int HOLD_CYCLES  = 300;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'd0;   // in_byte
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;          // key_valid, key_value[7:0], ctrl_mark, status[1:0]
    logic        m_axis_tuser;          // key_special

    terminal_escape_key_decoder_top DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    logic [7:0]  rx_bytes[$];
    t_key_result key_expected[$];
    logic [2:0]  tb_state = ST_PLAIN;
    int          bytes_sent = 0;
    int          beats_seen = 0;
    int          keys_seen = 0;
    int          specials_seen = 0;
    int          bad_status_seen = 0;
    int          errors = 0;
    int          tx_gap = 0;
    int          rx_stall = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // per-byte decode, advances the testbench copy of the decoder state
    function automatic t_key_result decode_rx_byte(input logic [7:0] rx);
        t_key_result r;
        logic [2:0]  nxt;
        r = '0;
        r.status = STS_OK;
        nxt = ST_PLAIN;
        case (tb_state)
            ST_PLAIN: begin
                if (rx == CH_ESC) begin
                    nxt = ST_ESC;
                end else if (rx < CH_SPACE) begin
                    r.valid = 1'b1;
                    r.value = CH_AT + rx;
                    r.ctrl  = 1'b1;
                end else begin
                    r.valid = 1'b1;
                    r.value = rx;
                end
            end
            ST_ESC: begin
                if (rx == CH_ESC) r.status = STS_IO_ERR;
                else if (rx == CH_SS3) nxt = ST_SS3;
                else if (rx == CH_CSI) nxt = ST_CSI;
            end
            ST_CSI: begin
                if (rx == CH_UP || rx == CH_DOWN || rx == CH_RIGHT || rx == CH_LEFT ||
                    rx == CH_END || rx == CH_HOME) begin
                    r.valid   = 1'b1;
                    r.special = 1'b1;
                    r.value   = rx - CH_UP;
                end else if (rx == CH_FIVE) begin
                    nxt = ST_PGUP;
                end else if (rx == CH_SIX) begin
                    nxt = ST_PGDN;
                end else if (rx == CH_TWO) begin
                    nxt = ST_INS;
                end else if (rx == CH_THREE) begin
                    nxt = ST_DEL;
                end
            end
            ST_SS3: begin
                if (rx >= CH_F1 && rx <= CH_F5) begin
                    r.valid   = 1'b1;
                    r.special = 1'b1;
                    r.value   = SP_F1 + (rx - CH_F1);
                end else begin
                    r.status = STS_INVALID;
                end
            end
            ST_DEL: begin
                if (rx == CH_TILDE) begin
                    r.valid   = 1'b1;
                    r.special = 1'b1;
                    r.value   = SP_DELETE;
                end else begin
                    r.status = STS_INVALID;
                end
            end
            default: begin
                if (rx != CH_TILDE) r.status = STS_INVALID;
            end
        endcase
        tb_state = nxt;
        return r;
    endfunction

    // idling is switched off for every third stretch of 256 beats
    function automatic int draw_wait(input int count);
        if ((count / 256) % 3 == 2) return 0;
        return $urandom_range(0, 7);
    endfunction

    function automatic logic [7:0] csi_final();
        logic [7:0] finals[6];
        finals = '{CH_UP, CH_DOWN, CH_RIGHT, CH_LEFT, CH_END, CH_HOME};
        return finals[$urandom_range(0, 5)];
    endfunction

    function automatic logic [7:0] tilde_lead();
        logic [7:0] leads[4];
        leads = '{CH_TWO, CH_THREE, CH_FIVE, CH_SIX};
        return leads[$urandom_range(0, 3)];
    endfunction

    // sender
    always @(posedge i_clk) begin
        int g;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_gap        <= 0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            key_expected.push_back(decode_rx_byte(s_axis_tdata));
            bytes_sent <= bytes_sent + 1;
            g = draw_wait(bytes_sent);
            if (g == 0 && rx_bytes.size() != 0) begin
                s_axis_tdata <= rx_bytes.pop_front();
            end else begin
                s_axis_tvalid <= 1'b0;
                tx_gap        <= g;
            end
        end else if (!s_axis_tvalid) begin
            if (tx_gap != 0) begin
                tx_gap <= tx_gap - 1;
            end else if (rx_bytes.size() != 0) begin
                s_axis_tdata  <= rx_bytes.pop_front();
                s_axis_tvalid <= 1'b1;
            end
        end
    end

    // receiver and checker
    always @(posedge i_clk) begin
        t_key_result exp_r;
        int w;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_stall      <= 0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            if (key_expected.size() == 0) begin
                $error("unexpected result beat tdata=%h tuser=%b", m_axis_tdata, m_axis_tuser);
                errors++;
            end else begin
                exp_r = key_expected.pop_front();
                if (m_axis_tdata[0] !== exp_r.valid) begin
                    $error("key_valid exp %0d got %0d", exp_r.valid, m_axis_tdata[0]);
                    errors++;
                end
                if (m_axis_tuser !== exp_r.special) begin
                    $error("key_special exp %0d got %0d", exp_r.special, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata[8:1] !== exp_r.value) begin
                    $error("key_value exp %0d got %0d", exp_r.value, m_axis_tdata[8:1]);
                    errors++;
                end
                if (m_axis_tdata[9] !== exp_r.ctrl) begin
                    $error("ctrl_mark exp %0d got %0d", exp_r.ctrl, m_axis_tdata[9]);
                    errors++;
                end
                if (m_axis_tdata[11:10] !== exp_r.status) begin
                    $error("status exp %0d got %0d", exp_r.status, m_axis_tdata[11:10]);
                    errors++;
                end
                if (exp_r.valid) keys_seen++;
                if (exp_r.special) specials_seen++;
                if (exp_r.status != STS_OK) bad_status_seen++;
            end
            beats_seen++;
            // one long hold-off so the pipe fills and backpressures the input
            w = (beats_seen == HOLD_AT_BEAT) ? HOLD_CYCLES : draw_wait(beats_seen + 128);
            if (w != 0) begin
                m_axis_tready <= 1'b0;
                rx_stall      <= w;
            end
        end else begin
            if (rx_stall != 0) rx_stall <= rx_stall - 1;
            m_axis_tready <= (rx_stall <= 1);
        end
    end

    initial begin
        logic [7:0] lead;
        int         kind;
        rx_bytes = '{8'h00, 8'hFF,
                     CH_ESC, CH_ESC,
                     CH_ESC, 8'h78,
                     CH_ESC, CH_CSI, CH_HOME,
                     CH_ESC, CH_CSI, CH_THREE, CH_TILDE,
                     CH_ESC, CH_CSI, CH_FIVE, CH_TILDE,
                     CH_ESC, CH_SS3, CH_F5,
                     CH_ESC, CH_SS3, 8'h55,
                     CH_ESC, CH_CSI, CH_TWO, 8'h71};
        while (rx_bytes.size() < RANDOM_BYTES) begin
            kind = $urandom_range(0, 9);
            case (kind)
                0, 1, 2: rx_bytes.push_back(8'($urandom_range(0, 255)));
                3: rx_bytes.push_back(csi_final());
                4: begin
                    rx_bytes.push_back(CH_ESC);
                    rx_bytes.push_back(CH_CSI);
                    rx_bytes.push_back(csi_final());
                end
                5: begin
                    rx_bytes.push_back(CH_ESC);
                    rx_bytes.push_back(CH_CSI);
                    rx_bytes.push_back(8'($urandom_range(0, 255)));
                end
                6: begin
                    rx_bytes.push_back(CH_ESC);
                    rx_bytes.push_back(CH_SS3);
                    rx_bytes.push_back(($urandom_range(0, 3) == 0) ?
                                       8'($urandom_range(0, 255)) :
                                       8'($urandom_range(CH_F1, CH_F5)));
                end
                7: begin
                    lead = tilde_lead();
                    rx_bytes.push_back(CH_ESC);
                    rx_bytes.push_back(CH_CSI);
                    rx_bytes.push_back(lead);
                    rx_bytes.push_back(($urandom_range(0, 3) == 0) ?
                                       8'($urandom_range(0, 255)) : CH_TILDE);
                end
                default: begin
                    rx_bytes.push_back(CH_ESC);
                    rx_bytes.push_back(($urandom_range(0, 2) == 0) ?
                                       CH_ESC : 8'($urandom_range(0, 255)));
                end
            endcase
        end

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (rx_bytes.size() != 0 || s_axis_tvalid || tx_gap != 0 ||
               key_expected.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("decoded %0d bytes into %0d result beats: %0d keys, %0d special",
                 bytes_sent, beats_seen, keys_seen, specials_seen);
        $display("%0d beats carried an error status, %0d mismatches", bad_status_seen, errors);
        if (errors == 0) begin
            $display("terminal_escape_key_decoder_top regression: pass");
        end else begin
            $display("terminal_escape_key_decoder_top regression: fail");
        end
        $finish;
    end

    initial begin
        #3ms;
        $display("terminal_escape_key_decoder_top regression: fail");
        $finish;
    end

endmodule
